// ===== hdl/bounded_set_span_finder_assert.svh =====
// ----------------------------------------------------------------------------
// bounded_set_span_finder_assert.svh
// assertion helpers for the span finder checker
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SET_SPAN_FINDER_ASSERT_SVH
`define BOUNDED_SET_SPAN_FINDER_ASSERT_SVH

// checked only out of reset
`define BSSF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// checked at every edge, reset included
`define BSSF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/bssf_pkg.sv =====
// ----------------------------------------------------------------------------
// bssf_pkg
// shared types and constants of the bounded set span finder
// ----------------------------------------------------------------------------
`default_nettype none

package bssf_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int VAL_W           = 32;
    localparam int CAP_W           = 7;
    localparam int STAT_W          = 2;

    localparam logic [CAP_W-1:0]  CAPACITY_RESET = 7'd64;
    localparam logic [VAL_W-1:0]  GAP_CEILING    = 32'hFFFF_FFFF;

    localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_TOO_FEW = 2'd2;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // broadcast to every cell
    typedef struct packed {
        logic             ins;
        logic [VAL_W-1:0] value;
    } t_ctrl;

    // what a cell hands to its right neighbor
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             valid;   // occupied, left boundary reads as occupied
        logic             live;    // holds a real value, left boundary reads as empty
        logic             gt;      // holds a value above the incoming one
        logic [VAL_W-1:0] min;     // running least neighbor gap
        logic [VAL_W-1:0] last;    // running last occupied value
    } t_link;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  shortest_span;
        logic [VAL_W-1:0]  longest_span;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/bssf_in_if.sv =====
// ----------------------------------------------------------------------------
// bssf_in_if
// request channel: action and value words
// ----------------------------------------------------------------------------
`default_nettype none

interface bssf_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

`default_nettype wire

// ===== hdl/bssf_out_if.sv =====
// ----------------------------------------------------------------------------
// bssf_out_if
// response channel: status and span words
// ----------------------------------------------------------------------------
`default_nettype none

interface bssf_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] shortest_span;
    logic [31:0] longest_span;

    modport source (output valid, output status, output shortest_span,
                    output longest_span, input ready);
    modport sink   (input valid, input status, input shortest_span,
                    input longest_span, output ready);
endinterface

`default_nettype wire

// ===== hdl/bounded_set_span_finder.sv =====
// ----------------------------------------------------------------------------
// bounded_set_span_finder
// sorted bounded multiset with shortest and longest span queries
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake        word
//  i_req     in    valid / ready    action, value
//  o_rsp     out   valid / ready    status, shortest_span, longest_span
//  i_cfg     in    write enable     capacity_limit (7 bits)
//
//  an add has every cell compare and shift in parallel
//  a query lets the gap minimum walk the cell chain
//  one cell per cycle before the answer is latched
//  reset clears the fill, the limit returns to 64; stored values are not cleared
//  a waiting response blocks the next request only when the output is stalled
//
`default_nettype none

module bounded_set_span_finder
    import bssf_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    bssf_in_if.sink          i_req,
    bssf_out_if.source       o_rsp
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

    // fsm codes
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SPAN = 1'b1;

    logic             r_state, n_state;
    logic [CAP_W-1:0] r_limit;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_span_cnt, n_span_cnt;
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;

    logic  w_accept;
    logic  w_out_free;
    logic  w_full;
    logic  w_span_done;
    t_ctrl w_ctrl;
    t_link w_link [MAX_ENTRIES+1];

    // output slot frees up when empty or being drained this cycle
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept    = i_req.valid && i_req.ready;

    // full when at storage size or at or above the programmed limit
    assign w_full = (r_count == CNT_MAX) ||
                    (LIM_W'(r_count) >= LIM_W'(r_limit));

    assign w_ctrl.ins   = w_accept && (i_req.action == ACT_ADD) && !w_full;
    assign w_ctrl.value = i_req.value;

    // left boundary: looks occupied for the shift logic, empty for gaps
    assign w_link[0].value = '0;
    assign w_link[0].valid = 1'b1;
    assign w_link[0].live  = 1'b0;
    assign w_link[0].gt    = 1'b0;
    assign w_link[0].min   = GAP_CEILING;
    assign w_link[0].last  = '0;

    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
        bssf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_left  (w_link[k]),
            .o_link  (w_link[k+1])
        );
    end

    // once the span counter reaches MAX_ENTRIES the tail cell holds the chain-wide minimum
    assign w_span_done = (r_span_cnt == CNT_MAX);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_span_cnt  = r_span_cnt;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_out.shortest_span = '0;
                    n_out.longest_span  = '0;
                    if (i_req.action == ACT_ADD) begin
                        n_out_valid = 1'b1;
                        if (w_full) begin
                            n_out.status = STATUS_FULL;
                        end else begin
                            n_out.status = STATUS_OK;
                            n_count      = r_count + CNT_W'(1);
                        end
                    end else if (r_count < CNT_TWO) begin
                        n_out_valid  = 1'b1;
                        n_out.status = STATUS_TOO_FEW;
                    end else begin
                        // values are settled, let the scan run the chain
                        n_span_cnt = '0;
                        n_state    = ST_SPAN;
                    end
                end
            end
            ST_SPAN: begin
                if (!w_span_done) begin
                    n_span_cnt = r_span_cnt + CNT_W'(1);
                end else if (w_out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.status        = STATUS_OK;
                    n_out.shortest_span = w_link[MAX_ENTRIES].min;
                    n_out.longest_span  = w_link[MAX_ENTRIES].last - w_link[1].value;
                    n_state             = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_limit     <= CAPACITY_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_span_cnt <= n_span_cnt;
        r_out      <= n_out;
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.shortest_span = r_out.shortest_span;
    assign o_rsp.longest_span  = r_out.longest_span;

endmodule

`default_nettype wire

// ===== hdl/bssf_cell.sv =====
// ----------------------------------------------------------------------------
// bssf_cell
// one slot of the sorted chain: insert shift and span scan step
// ----------------------------------------------------------------------------
`default_nettype none

module bssf_cell
    import bssf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ctrl i_ctrl,
    input  t_link i_left,
    output t_link o_link
);

    logic [VAL_W-1:0] r_value, n_value;
    logic             r_valid, n_valid;
    logic [VAL_W-1:0] r_min, n_min;
    logic [VAL_W-1:0] r_last, n_last;
    logic             w_gt;
    logic [VAL_W-1:0] w_gap;
    logic [VAL_W-1:0] w_cand;

    assign w_gt = r_valid && ($signed(r_value) > $signed(i_ctrl.value));

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.ins) begin
            if (i_left.gt) begin
                n_value = i_left.value;
            end else if (w_gt || (!r_valid && i_left.valid)) begin
                n_value = i_ctrl.value;
            end
            n_valid = r_valid | i_left.valid;
        end
    end

    // difference wraps to the exact unsigned gap since neighbors are ordered
    assign w_gap  = r_value - i_left.value;
    assign w_cand = (r_valid && i_left.live) ? w_gap : GAP_CEILING;

    always_comb begin
        n_min  = (w_cand < i_left.min) ? w_cand : i_left.min;
        n_last = r_valid ? r_value : i_left.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_min   <= n_min;
        r_last  <= n_last;
    end

    assign o_link.value = r_value;
    assign o_link.valid = r_valid;
    assign o_link.live  = r_valid;
    assign o_link.gt    = w_gt;
    assign o_link.min   = r_min;
    assign o_link.last  = r_last;

endmodule

`default_nettype wire

// ===== hdl/bssf_checker.sv =====
// ----------------------------------------------------------------------------
// bssf_checker
// port-level checks of the span finder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_set_span_finder_assert.svh"

module bssf_checker
    import bssf_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_req_valid,
    input wire logic              i_req_ready,
    input wire logic              i_rsp_valid,
    input wire logic              i_rsp_ready,
    input wire logic [STAT_W-1:0] i_rsp_status,
    input wire logic [VAL_W-1:0]  i_rsp_shortest,
    input wire logic [VAL_W-1:0]  i_rsp_longest
);

    `BSSF_ASSERT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid, "response dropped while stalled")
    `BSSF_ASSERT(a_no_overrun, i_clk, i_rst_n, i_req_valid && i_req_ready |-> !i_rsp_valid || i_rsp_ready, "request taken over a stalled response")
    `BSSF_ASSERT(a_fail_zero, i_clk, i_rst_n, i_rsp_valid && (i_rsp_status != STATUS_OK) |-> (i_rsp_shortest == '0) && (i_rsp_longest == '0), "spans not zero on a non-ok status")
    `BSSF_ASSERT(a_status_code, i_clk, i_rst_n, i_rsp_valid |-> (i_rsp_status == STATUS_OK) || (i_rsp_status == STATUS_FULL) || (i_rsp_status == STATUS_TOO_FEW), "unknown status code")
    `BSSF_ASSERT_ALWAYS(a_reset_quiet, i_clk, $past(i_rst_n) == 1'b0 |-> !i_rsp_valid, "response valid right after reset")

endmodule

bind bounded_set_span_finder bssf_checker u_bssf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_status   (o_rsp.status),
    .i_rsp_shortest (o_rsp.shortest_span),
    .i_rsp_longest  (o_rsp.longest_span)
);

`default_nettype wire
